[rtl/core/pph_pkg.sv]
// Shared types, constants and helper functions of the pinhole projection block.
`timescale 1ns / 1ps

package pph_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS  = 16;
    localparam int ROT_FRAC   = 16;
    localparam int ROT_W      = 18;
    localparam int NEAR_MARGIN = 66;
    localparam logic signed [31:0] NEAR_LIMIT = -32'(NEAR_MARGIN);

    // Divider geometry: quotient magnitude bits, numerator and compare widths.
    localparam int QW      = 34;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 32;
    localparam int DIVR_W  = DEN_W + QW;
    localparam int DIV_LAT = QW + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_RIGHT  = 4'd0,
        CFG_ROT_UP     = 4'd1,
        CFG_ROT_BACK   = 4'd2,
        CFG_EYE_X      = 4'd3,
        CFG_EYE_Y      = 4'd4,
        CFG_EYE_Z      = 4'd5,
        CFG_FOCAL_PAIR = 4'd6,
        CFG_CENTER_PAIR = 4'd7
    } t_cfg_idx;

    // One input item.
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [31:0] grad_u;
        logic signed [31:0] grad_v;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] screen_u;
        logic signed [31:0] screen_v;
        logic signed [31:0] world_grad_x;
        logic signed [31:0] world_grad_y;
        logic signed [31:0] world_grad_z;
        logic               behind_near;
    } t_out_item;

    // Saturate a sign-extended value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [DIVR_W-1:0] x);
        logic signed [31:0] res;
        if ((x[DIVR_W-1:31] == '0) || (x[DIVR_W-1:31] == '1)) begin
            res = x[31:0];
        end else begin
            res = x[DIVR_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Pick one signed Q2.16 entry out of a packed rotation row.
    function automatic logic signed [ROT_W-1:0] rot_entry(input logic [3*ROT_W-1:0] row,
                                                          input int col);
        return row[ROT_W*col +: ROT_W];
    endfunction

endpackage

[rtl/core/pph_div.sv]
// Pipelined signed divider, one quotient bit per stage, saturating quotient.
`timescale 1ns / 1ps

module pph_div import pph_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [DEN_W-1:0]  i_den,
    output logic signed [QW:0]       o_quo
);

    logic [NUM_W-1:0] r_rem [0:QW];
    logic [DEN_W-1:0] r_den [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic             r_neg [0:QW];
    logic             r_ovf [0:QW];

    logic [NUM_W-1:0] n_rem [1:QW];
    logic [QW-1:0]    n_q   [1:QW];
    logic             n_ovf [1:QW];
    logic [DIVR_W-1:0] shd  [0:QW-1];
    logic [DIVR_W-1:0] rem_w [0:QW-1];
    logic             ge    [0:QW-1];
    logic [QW-1:0]    mag;

    // Each stage compares the remainder with the shifted divisor for one bit.
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            shd[s]   = DIVR_W'(r_den[s]) << (QW - 1 - s);
            rem_w[s] = DIVR_W'(r_rem[s]);
            ge[s]    = rem_w[s] >= shd[s];
            n_rem[s+1] = ge[s] ? NUM_W'(rem_w[s] - shd[s]) : r_rem[s];
            n_q[s+1] = r_q[s];
            n_q[s+1][QW-1-s] = ge[s];
            if (s == 0) begin
                n_ovf[s+1] = rem_w[s] >= (DIVR_W'(r_den[s]) << QW);
            end else begin
                n_ovf[s+1] = r_ovf[s];
            end
        end
        mag = r_ovf[QW] ? '1 : r_q[QW];
    end

    // Operand magnitudes enter the first stage; the signed result leaves the last.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_den[0] <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_ovf[0] <= 1'b0;
            for (int s = 1; s <= QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= n_q[s];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= n_ovf[s];
            end
            o_quo <= r_neg[QW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

endmodule

[rtl/core/pinhole_projection_with_gradient.sv]
// Top level of the pinhole projection block with screen-to-world gradient pullback.
`timescale 1ns / 1ps

// The block accepts one item per clock while its skid stage is empty and
// returns one result per item, in order. Two chained divider pipelines (one
// quotient bit per stage) divide by camera depth, first for the focal terms
// and then for the second-order Jacobian term. An output register with a
// one-item skid stage lets a new item in while a result waits; a stall that
// fills the skid stage holds the whole pipeline. Configuration is written
// through a plain write port and must only change while the block is idle.

module pinhole_projection_with_gradient import pph_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    // Side data carried past the first divider.
    typedef struct packed {
        logic               op;
        logic               behind;
        logic signed [31:0] gu;
        logic signed [31:0] gv;
        logic signed [31:0] pz;
    } t_side1;

    // Side data carried past the second divider.
    typedef struct packed {
        logic               op;
        logic               behind;
        logic signed [31:0] gu;
        logic signed [31:0] gv;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] au;
        logic signed [31:0] av;
    } t_side2;

    // Configuration registers.
    logic [3*ROT_W-1:0]     r_rot [0:2];
    logic signed [31:0]     r_eye [0:2];
    logic [CFG_DATA_W-1:0]  r_focal;
    logic [CFG_DATA_W-1:0]  r_center;

    logic signed [31:0] fx, fy, cx, cy;
    assign fx = r_focal[31:0];
    assign fy = r_focal[63:32];
    assign cx = r_center[31:0];
    assign cy = r_center[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= 54'(65536);
            r_rot[1] <= 54'(65536) << ROT_W;
            r_rot[2] <= 54'(65536) << (2 * ROT_W);
            r_eye[0] <= '0;
            r_eye[1] <= '0;
            r_eye[2] <= '0;
            r_focal  <= '0;
            r_center <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_RIGHT:   r_rot[0] <= i_cfg_data[3*ROT_W-1:0];
                CFG_ROT_UP:      r_rot[1] <= i_cfg_data[3*ROT_W-1:0];
                CFG_ROT_BACK:    r_rot[2] <= i_cfg_data[3*ROT_W-1:0];
                CFG_EYE_X:       r_eye[0] <= i_cfg_data[31:0];
                CFG_EYE_Y:       r_eye[1] <= i_cfg_data[31:0];
                CFG_EYE_Z:       r_eye[2] <= i_cfg_data[31:0];
                CFG_FOCAL_PAIR:  r_focal  <= i_cfg_data;
                CFG_CENTER_PAIR: r_center <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: the whole pipeline moves unless the skid stage is full.
    logic en;
    logic r_out_v, r_skid_v;
    t_out_item r_out, r_skid;
    assign en = !r_skid_v;
    assign o_in_ready = en;

    // Valid bits of the pipeline.
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic [DIV_LAT-1:0] r_dl1_v, r_dl2_v;

    // Payload registers.
    logic               r1_op;
    logic signed [31:0] r1_gu, r1_gv;
    logic signed [32:0] r1_d [0:2];
    logic               r2_op;
    logic signed [31:0] r2_gu, r2_gv;
    logic signed [50:0] r2_prod [0:2][0:2];
    logic               r3_op;
    logic signed [31:0] r3_gu, r3_gv;
    logic signed [31:0] r3_p [0:2];
    t_side1             r4_side;
    logic signed [NUM_W-1:0] r4_nqx, r4_nqy, r4_nau, r4_nav;
    t_side1             r_dl1 [0:DIV_LAT-1];
    t_side2             r5_side;
    logic signed [31:0] r5_pz;
    logic signed [NUM_W-1:0] r5_nbu, r5_nbv;
    t_side2             r_dl2 [0:DIV_LAT-1];
    t_side2             r6_side;
    logic signed [49:0] r6_pa [0:2];
    logic signed [49:0] r6_pb [0:2];
    logic signed [49:0] r6_pc [0:2];
    logic signed [49:0] r6_pd [0:2];
    t_side2             r7_side;
    logic signed [31:0] r7_ju [0:2];
    logic signed [31:0] r7_jv [0:2];
    t_side2             r8_side;
    logic signed [63:0] r8_gp [0:2];
    logic signed [63:0] r8_gq [0:2];

    // Divider results.
    logic signed [QW:0] qx, qy, qau, qav, qbu, qbv;

    // Stage 3 row sums, floored and saturated into camera space.
    logic signed [52:0] n_acc [0:2];
    logic signed [52:0] n_accs [0:2];
    logic signed [31:0] n_p [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i]  = 53'(r2_prod[i][0]) + 53'(r2_prod[i][1]) + 53'(r2_prod[i][2]);
            n_accs[i] = n_acc[i] >>> ROT_FRAC;
            n_p[i]    = sat32(DIVR_W'(n_accs[i]));
        end
    end

    // First divider bank: focal terms over depth.
    pph_div u_div_qx (.i_clk(i_clk), .i_en(en), .i_num(r4_nqx), .i_den(r4_side.pz),
                      .o_quo(qx));
    pph_div u_div_qy (.i_clk(i_clk), .i_en(en), .i_num(r4_nqy), .i_den(r4_side.pz),
                      .o_quo(qy));
    pph_div u_div_au (.i_clk(i_clk), .i_en(en), .i_num(r4_nau), .i_den(r4_side.pz),
                      .o_quo(qau));
    pph_div u_div_av (.i_clk(i_clk), .i_en(en), .i_num(r4_nav), .i_den(r4_side.pz),
                      .o_quo(qav));

    // Stage 5: screen coordinates and the second numerators.
    t_side1             s1;
    logic signed [31:0] n_qu, n_qv;
    assign s1   = r_dl1[DIV_LAT-1];
    assign n_qu = sat32(DIVR_W'(qx));
    assign n_qv = sat32(DIVR_W'(qy));

    // Second divider bank: projected offset over depth again.
    pph_div u_div_bu (.i_clk(i_clk), .i_en(en), .i_num(r5_nbu), .i_den(r5_pz),
                      .o_quo(qbu));
    pph_div u_div_bv (.i_clk(i_clk), .i_en(en), .i_num(r5_nbv), .i_den(r5_pz),
                      .o_quo(qbv));

    t_side2             s2;
    logic signed [31:0] n_bu, n_bv;
    assign s2   = r_dl2[DIV_LAT-1];
    assign n_bu = sat32(DIVR_W'(qbu));
    assign n_bv = sat32(DIVR_W'(qbv));

    // Stage 7 Jacobian entries through the rotation.
    logic signed [50:0] n_su [0:2];
    logic signed [50:0] n_sv [0:2];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_su[c] = (51'(r6_pa[c]) + 51'(r6_pb[c])) >>> ROT_FRAC;
            n_sv[c] = (51'(r6_pc[c]) + 51'(r6_pd[c])) >>> ROT_FRAC;
        end
    end

    // Tail: gradient sums and final field selection.
    logic signed [64:0] t_sum [0:2];
    logic signed [64:0] t_shs [0:2];
    logic signed [31:0] t_g [0:2];
    t_out_item          tail;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t_sum[c] = 65'(r8_gp[c]) + 65'(r8_gq[c]);
            t_shs[c] = t_sum[c] >>> FRAC_BITS;
            t_g[c]   = sat32(DIVR_W'(t_shs[c]));
        end
        tail = '0;
        tail.behind_near = r8_side.behind;
        if (!r8_side.behind) begin
            if (!r8_side.op) begin
                tail.screen_u = r8_side.u;
                tail.screen_v = r8_side.v;
            end else begin
                tail.world_grad_x = t_g[0];
                tail.world_grad_y = t_g[1];
                tail.world_grad_z = t_g[2];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_dl1_v <= '0;
            r_dl2_v <= '0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_dl1_v <= {r_dl1_v[DIV_LAT-2:0], r4_v};
            r5_v <= r_dl1_v[DIV_LAT-1];
            r_dl2_v <= {r_dl2_v[DIV_LAT-2:0], r5_v};
            r6_v <= r_dl2_v[DIV_LAT-1];
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1: offset from the eye.
            r1_op   <= i_in.opcode;
            r1_gu   <= i_in.grad_u;
            r1_gv   <= i_in.grad_v;
            r1_d[0] <= 33'(i_in.world_x) - 33'(r_eye[0]);
            r1_d[1] <= 33'(i_in.world_y) - 33'(r_eye[1]);
            r1_d[2] <= 33'(i_in.world_z) - 33'(r_eye[2]);

            // Stage 2: rotation products.
            r2_op <= r1_op;
            r2_gu <= r1_gu;
            r2_gv <= r1_gv;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_prod[i][k] <= 51'(rot_entry(r_rot[i], k) * r1_d[k]);
                end
            end

            // Stage 3: camera-space point.
            r3_op <= r2_op;
            r3_gu <= r2_gu;
            r3_gv <= r2_gv;
            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= n_p[i];
            end

            // Stage 4: numerators and the near-plane test.
            r4_side.op     <= r3_op;
            r4_side.behind <= r3_p[2] > NEAR_LIMIT;
            r4_side.gu     <= r3_gu;
            r4_side.gv     <= r3_gv;
            r4_side.pz     <= r3_p[2];
            r4_nqx <= NUM_W'(fx * r3_p[0]);
            r4_nqy <= NUM_W'(fy * r3_p[1]);
            r4_nau <= NUM_W'(-NUM_W'(fx)) <<< FRAC_BITS;
            r4_nav <= NUM_W'(-NUM_W'(fy)) <<< FRAC_BITS;

            // Side data across the first divider bank.
            r_dl1[0] <= r4_side;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dl1[j] <= r_dl1[j-1];
            end

            // Stage 5: screen point and second numerators.
            r5_side.op     <= s1.op;
            r5_side.behind <= s1.behind;
            r5_side.gu     <= s1.gu;
            r5_side.gv     <= s1.gv;
            r5_side.u      <= sat32(DIVR_W'(cx) - DIVR_W'(qx));
            r5_side.v      <= sat32(DIVR_W'(cy) - DIVR_W'(qy));
            r5_side.au     <= sat32(DIVR_W'(qau));
            r5_side.av     <= sat32(DIVR_W'(qav));
            r5_pz  <= s1.pz;
            r5_nbu <= NUM_W'(n_qu) <<< FRAC_BITS;
            r5_nbv <= NUM_W'(n_qv) <<< FRAC_BITS;

            // Side data across the second divider bank.
            r_dl2[0] <= r5_side;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dl2[j] <= r_dl2[j-1];
            end

            // Stage 6: Jacobian products with the rotation rows.
            r6_side <= s2;
            for (int c = 0; c < 3; c++) begin
                r6_pa[c] <= 50'(s2.au * rot_entry(r_rot[0], c));
                r6_pb[c] <= 50'(n_bu * rot_entry(r_rot[2], c));
                r6_pc[c] <= 50'(s2.av * rot_entry(r_rot[1], c));
                r6_pd[c] <= 50'(n_bv * rot_entry(r_rot[2], c));
            end

            // Stage 7: Jacobian entries.
            r7_side <= r6_side;
            for (int c = 0; c < 3; c++) begin
                r7_ju[c] <= sat32(DIVR_W'(n_su[c]));
                r7_jv[c] <= sat32(DIVR_W'(n_sv[c]));
            end

            // Stage 8: gradient products.
            r8_side <= r7_side;
            for (int c = 0; c < 3; c++) begin
                r8_gp[c] <= 64'(r7_side.gu * r7_ju[c]);
                r8_gq[c] <= 64'(r7_side.gv * r7_jv[c]);
            end
        end
    end

    // Output register with a one-item skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r8_v) begin
                if (!r_out_v || i_out_ready) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r8_v) begin
                if (!r_out_v || i_out_ready) begin
                    r_out <= tail;
                end else begin
                    r_skid <= tail;
                end
            end
        end else if (i_out_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // A full skid stage always sits behind a waiting output item.
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage full without a valid output item");

    // An item behind the near plane carries only zero numeric fields.
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.behind_near) |->
        (o_out.screen_u == 0 && o_out.screen_v == 0 && o_out.world_grad_x == 0 &&
         o_out.world_grad_y == 0 && o_out.world_grad_z == 0))
        else $error("behind-near item has nonzero fields");

    // A stalled output item holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output item changed while stalled");

endmodule
